// ===== rtl/core/sonar_ascii_range_parser_averager_defines.svh =====
// Assertion macros for the sonar range parser and averager.
// Used by the controller and datapath; needs aclk and aresetn in the including module.
`ifndef SONAR_ASCII_RANGE_PARSER_AVERAGER_DEFINES_SVH
`define SONAR_ASCII_RANGE_PARSER_AVERAGER_DEFINES_SVH
`ifndef SYNTHESIS
`define SARPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define SARPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SARPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SARPA_ASSERT(label, prop, msg)
`define SARPA_ASSERT_IMPL(label, ante, cons, msg)
`define SARPA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/sarpa_pkg.sv =====
// Shared types and constants for the sonar range parser and averager.
// No dependencies.
package sarpa_pkg;

    localparam logic [7:0] CH_START = 8'h52;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [2:0] POS_WAIT = 3'd0;
    localparam logic [2:0] POS_HUND = 3'd1;
    localparam logic [2:0] POS_TENS = 3'd2;
    localparam logic [2:0] POS_UNIT = 3'd3;
    localparam logic [2:0] POS_CR   = 3'd4;

    localparam logic [4:0] BATCH_MIN = 5'd1;
    localparam logic [4:0] BATCH_MAX = 5'd16;
    localparam logic [9:0] READING_MAX = 10'd999;

    localparam int SUM_W  = 14;
    localparam int FILL_W = 5;
    localparam logic [3:0] DIV_LAST_STEP = 4'(SUM_W - 1);

    localparam logic CFG_READINGS  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [4:0] RST_READINGS  = 5'd8;
    localparam logic [9:0] RST_THRESHOLD = 10'd50;

    typedef struct packed {
        logic accept;
        logic capture;
        logic div_step;
        logic load_out;
    } sarpa_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic batch_done;
        logic div_last;
    } sarpa_status_t;

endpackage

// ===== rtl/core/sonar_ascii_range_parser_averager.sv =====
// Sonar range parser and averager, top level.
// Input channel s_*: one received serial byte per item. Frames are 'R', three
// ASCII digits and CR; other bytes are skipped or drop the current frame.
// Output channel m_*: one item per completed frame with the parsed reading;
// every Nth reading also carries the batch mean and the turn-left flag.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 readings per batch, 1 turn threshold) in the same cycle.
// Throughput: one byte per cycle while no frame completes. A CR that closes
// a frame is captured, then loaded into the output register from the push
// state; when it closes a batch, the 14-step serial divider runs in between.
// Reset (aresetn low, synchronous) empties the parser and batch and loads
// 8 readings per batch and a threshold of 50.
// A stalled receiver keeps the result in the output register; bytes are still
// taken until another frame completes, then s_ready drops until it drains.
// Depends on sarpa_pkg, sarpa_ctrl and sarpa_dp.
module sonar_ascii_range_parser_averager (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [9:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [9:0] m_reading,
    output logic       m_mean_ready,
    output logic [9:0] m_mean_distance,
    output logic       m_turn_left
);

    sarpa_pkg::sarpa_cmd_t    cmd;
    sarpa_pkg::sarpa_status_t status;

    sarpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sarpa_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_rx_byte       (s_rx_byte),
        .cmd             (cmd),
        .status          (status),
        .m_reading       (m_reading),
        .m_mean_ready    (m_mean_ready),
        .m_mean_distance (m_mean_distance),
        .m_turn_left     (m_turn_left)
    );

endmodule

// ===== rtl/core/sarpa_dp.sv =====
// Datapath: frame parser, batch accumulator, serial divider and output register.
// Depends on sarpa_pkg and the assertion macro header.
`include "sonar_ascii_range_parser_averager_defines.svh"

module sarpa_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [9:0]            cfg_wdata,
    input  logic [7:0]            s_rx_byte,
    input  sarpa_pkg::sarpa_cmd_t cmd,
    output sarpa_pkg::sarpa_status_t status,
    output logic [9:0]            m_reading,
    output logic                  m_mean_ready,
    output logic [9:0]            m_mean_distance,
    output logic                  m_turn_left
);

    logic [4:0] readings_reg;
    logic [9:0] threshold_reg;

    logic [2:0] pos_reg, pos_next;
    logic [9:0] partial_reg, partial_next;
    logic [sarpa_pkg::SUM_W-1:0]  sum_reg, sum_next, sum_new;
    logic [sarpa_pkg::FILL_W-1:0] fill_reg, fill_next, fill_new;
    logic [4:0] eff_batch;

    logic [9:0] reading_reg;
    logic       mean_ready_reg;
    logic [sarpa_pkg::SUM_W-1:0]  quo_reg, quo_next;
    logic [sarpa_pkg::FILL_W-1:0] rem_reg, rem_next, divisor_reg;
    logic [3:0] step_reg;
    logic [sarpa_pkg::FILL_W:0]   rem_shift;
    logic       rem_ge;

    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] weight;
    logic [9:0] mean_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            readings_reg  <= sarpa_pkg::RST_READINGS;
            threshold_reg <= sarpa_pkg::RST_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sarpa_pkg::CFG_READINGS:  readings_reg  <= cfg_wdata[4:0];
                sarpa_pkg::CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign is_digit = (s_rx_byte >= sarpa_pkg::CH_ZERO) &&
                      (s_rx_byte <= sarpa_pkg::CH_ZERO + 8'd9);
    assign digit    = 4'(s_rx_byte - sarpa_pkg::CH_ZERO);

    always_comb begin
        case (pos_reg)
            sarpa_pkg::POS_HUND: weight = 7'd100;
            sarpa_pkg::POS_TENS: weight = 7'd10;
            default:             weight = 7'd1;
        endcase
    end

    always_comb begin
        if (readings_reg == 5'd0) begin
            eff_batch = sarpa_pkg::BATCH_MIN;
        end else if (readings_reg > sarpa_pkg::BATCH_MAX) begin
            eff_batch = sarpa_pkg::BATCH_MAX;
        end else begin
            eff_batch = readings_reg;
        end
    end

    assign sum_new  = sum_reg + sarpa_pkg::SUM_W'(partial_reg);
    assign fill_new = fill_reg + 5'd1;

    assign status.frame_done = (pos_reg == sarpa_pkg::POS_CR) && (s_rx_byte == sarpa_pkg::CH_CR);
    assign status.batch_done = fill_new >= eff_batch;
    assign status.div_last   = step_reg == sarpa_pkg::DIV_LAST_STEP;

    always_comb begin
        pos_next     = pos_reg;
        partial_next = partial_reg;
        if (cmd.accept) begin
            case (pos_reg)
                sarpa_pkg::POS_WAIT: begin
                    if (s_rx_byte == sarpa_pkg::CH_START) begin
                        pos_next     = sarpa_pkg::POS_HUND;
                        partial_next = 10'd0;
                    end
                end
                sarpa_pkg::POS_HUND, sarpa_pkg::POS_TENS, sarpa_pkg::POS_UNIT: begin
                    if (is_digit) begin
                        partial_next = partial_reg + 10'(digit) * 10'(weight);
                        pos_next     = pos_reg + 3'd1;
                    end else begin
                        pos_next     = sarpa_pkg::POS_WAIT;
                        partial_next = 10'd0;
                    end
                end
                default: begin
                    pos_next     = sarpa_pkg::POS_WAIT;
                    partial_next = 10'd0;
                end
            endcase
        end
    end

    always_comb begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        if (cmd.capture) begin
            if (status.batch_done) begin
                sum_next  = '0;
                fill_next = '0;
            end else begin
                sum_next  = sum_new;
                fill_next = fill_new;
            end
        end
    end

    assign rem_shift = {rem_reg, quo_reg[sarpa_pkg::SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_next  = rem_ge ? sarpa_pkg::FILL_W'(rem_shift - {1'b0, divisor_reg})
                              : rem_shift[sarpa_pkg::FILL_W-1:0];
    assign quo_next  = {quo_reg[sarpa_pkg::SUM_W-2:0], rem_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= sarpa_pkg::POS_WAIT;
            partial_reg <= 10'd0;
            sum_reg     <= '0;
            fill_reg    <= '0;
            step_reg    <= 4'd0;
        end else begin
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            if (cmd.capture) begin
                step_reg <= 4'd0;
            end else if (cmd.div_step) begin
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            reading_reg    <= partial_reg;
            mean_ready_reg <= status.batch_done;
            quo_reg        <= sum_new;
            rem_reg        <= '0;
            divisor_reg    <= fill_new;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign mean_value = quo_reg[9:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_reading       <= reading_reg;
            m_mean_ready    <= mean_ready_reg;
            m_mean_distance <= mean_ready_reg ? mean_value : 10'd0;
            m_turn_left     <= mean_ready_reg && (mean_value < threshold_reg);
        end
    end

    `SARPA_ASSERT_IMPL(a_rem_below_divisor, cmd.div_step, rem_reg < divisor_reg, "divider remainder out of range")
    `SARPA_ASSERT(a_fill_bounded, fill_reg < sarpa_pkg::BATCH_MAX, "batch fill beyond batch size")
    `SARPA_ASSERT(a_partial_bounded, partial_reg <= sarpa_pkg::READING_MAX, "partial reading above 999")

endmodule

// ===== rtl/core/sarpa_ctrl.sv =====
// Controller: sequences byte intake, the serial divide and the output handoff.
// Depends on sarpa_pkg and the assertion macro header.
`include "sonar_ascii_range_parser_averager_defines.svh"

module sarpa_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    input  sarpa_pkg::sarpa_status_t status,
    output sarpa_pkg::sarpa_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.frame_done) begin
                        cmd.capture = 1'b1;
                        state_next  = status.batch_done ? S_DIV : S_PUSH;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

    `SARPA_ASSERT_NEXT(a_push_fills_output, state_reg == S_PUSH && !m_valid_reg, m_valid_reg, "free output not loaded")
    `SARPA_ASSERT_NEXT(a_div_ends_in_push, state_reg == S_DIV && status.div_last, state_reg == S_PUSH, "divide did not hand off")
    `SARPA_ASSERT_IMPL(a_no_load_while_busy, cmd.load_out, !m_valid_reg || m_ready, "output overwritten")

endmodule
